// ===== sv/b2da_pkg.sv =====
// b2da_pkg: shared constants and types for the binary to decimal ascii converter
// used by b2da_cell and binary_to_decimal_ascii; no dependencies
package b2da_pkg;

  localparam int VALUE_BITS = 32;
  localparam int IN_BITS    = 32;
  localparam int USED_BITS  = (VALUE_BITS < IN_BITS) ? VALUE_BITS : IN_BITS;
  // decimal digits needed for the largest USED_BITS value (1233/4096 ~ log10 2)
  localparam int NUM_DIGITS = ((USED_BITS * 1233) >> 12) + 1;
  localparam int CNT_W      = $clog2(USED_BITS);
  localparam int REM_W      = $clog2(NUM_DIGITS + 1);
  localparam int CHAR_W     = 6;
  localparam logic [CHAR_W-1:0] ASCII_ZERO = CHAR_W'(48);

  typedef logic [3:0] bcd_t;

  typedef struct packed {
    logic clear;
    logic convert;
    logic move;
  } cell_ctrl_t;

endpackage

// ===== sv/b2da_cell.sv =====
// b2da_cell: one decimal digit of the conversion chain
// shift-and-add-3 step, or a plain move of the neighbour's digit; uses b2da_pkg
module b2da_cell (
  input  logic                 clk_i,
  input  b2da_pkg::cell_ctrl_t ctrl_i,
  input  logic                 bit_i,
  input  b2da_pkg::bcd_t       digit_i,
  output logic                 carry_o,
  output b2da_pkg::bcd_t       digit_o
);
  import b2da_pkg::*;

  bcd_t digit_q, digit_d;
  bcd_t adj;

  assign adj     = (digit_q >= 4'd5) ? digit_q + 4'd3 : digit_q;
  assign carry_o = adj[3];
  assign digit_o = digit_q;

  always_comb begin
    digit_d = digit_q;
    if (ctrl_i.clear) begin
      digit_d = '0;
    end else if (ctrl_i.convert) begin
      digit_d = {adj[2:0], bit_i};
    end else if (ctrl_i.move) begin
      digit_d = digit_i;
    end
  end

  always_ff @(posedge clk_i) begin
    digit_q <= digit_d;
  end

endmodule

// ===== sv/binary_to_decimal_ascii.sv =====
// binary_to_decimal_ascii: top level of the binary to decimal ascii converter
// depends on b2da_pkg and b2da_cell
//
// Converts one unsigned 32-bit request to its decimal text, one ASCII digit per output request,
// most significant first, no leading zeros, last_o on the final digit. A chain of ten digit
// cells runs one shift-and-add-3 step per cycle, then shifts its digits out one per cycle
// toward the output register while the output slot is free; leading zeros are dropped at one
// per cycle on the way, under the same condition. A request occupies the block for a load,
// the conversion steps and the digit moves, plus any output stall; a new request is taken as
// soon as the last digit is in the output register.
module binary_to_decimal_ascii (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  logic [b2da_pkg::IN_BITS-1:0]  value_i,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output logic [b2da_pkg::CHAR_W-1:0]   character_o,
  output logic                          last_o
);
  import b2da_pkg::*;

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_CONV = 2'd1;
  localparam logic [1:0] ST_EMIT = 2'd2;

  logic [1:0]           state_q, state_d;
  logic [USED_BITS-1:0] val_q, val_d;
  logic [CNT_W-1:0]     cnt_q, cnt_d;
  logic [REM_W-1:0]     rem_q, rem_d;
  logic                 started_q, started_d;
  logic                 out_valid_q, out_valid_d;
  logic [CHAR_W-1:0]    char_q, char_d;
  logic                 last_q, last_d;

  cell_ctrl_t ctrl;
  logic       carry [NUM_DIGITS];
  bcd_t       digit [NUM_DIGITS];
  bcd_t       top_digit;
  logic       accept, slot_free;

  for (genvar i = 0; i < NUM_DIGITS; i++) begin : g_cell
    b2da_cell u_cell (
      .clk_i   (clk_i),
      .ctrl_i  (ctrl),
      .bit_i   ((i == 0) ? val_q[USED_BITS-1] : carry[(i == 0) ? 0 : i-1]),
      .digit_i ((i == 0) ? bcd_t'(0) : digit[(i == 0) ? 0 : i-1]),
      .carry_o (carry[i]),
      .digit_o (digit[i])
    );
  end

  assign top_digit   = digit[NUM_DIGITS-1];
  assign in_stall_o  = (state_q != ST_IDLE);
  assign accept      = in_valid_i && !in_stall_o;
  assign slot_free   = !out_valid_q || !out_stall_i;
  assign out_valid_o = out_valid_q;
  assign character_o = char_q;
  assign last_o      = last_q;

  always_comb begin
    state_d     = state_q;
    val_d       = val_q;
    cnt_d       = cnt_q;
    rem_d       = rem_q;
    started_d   = started_q;
    out_valid_d = out_valid_q && out_stall_i;
    char_d      = char_q;
    last_d      = last_q;
    ctrl        = '0;
    case (state_q)
      ST_IDLE: begin
        if (accept) begin
          val_d      = value_i[USED_BITS-1:0];
          cnt_d      = '0;
          ctrl.clear = 1'b1;
          state_d    = ST_CONV;
        end
      end
      ST_CONV: begin
        ctrl.convert = 1'b1;
        val_d        = val_q << 1;
        cnt_d        = cnt_q + 1'b1;
        if (cnt_q == CNT_W'(USED_BITS - 1)) begin
          rem_d     = REM_W'(NUM_DIGITS);
          started_d = 1'b0;
          state_d   = ST_EMIT;
        end
      end
      ST_EMIT: begin
        if (slot_free) begin
          ctrl.move = 1'b1;
          rem_d     = rem_q - 1'b1;
          // leading zeros are shifted past without output
          if (started_q || top_digit != '0 || rem_q == REM_W'(1)) begin
            started_d   = 1'b1;
            out_valid_d = 1'b1;
            char_d      = ASCII_ZERO + CHAR_W'(top_digit);
            last_d      = (rem_q == REM_W'(1));
            if (rem_q == REM_W'(1)) begin
              state_d = ST_IDLE;
            end
          end
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
      started_q   <= 1'b0;
      cnt_q       <= '0;
      rem_q       <= '0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
      started_q   <= started_d;
      cnt_q       <= cnt_d;
      rem_q       <= rem_d;
    end
  end

  always_ff @(posedge clk_i) begin
    val_q  <= val_d;
    char_q <= char_d;
    last_q <= last_d;
  end

endmodule

// ===== sv/b2da_checker.sv =====
// b2da_checker: port-level checks for binary_to_decimal_ascii, bound to the top level
// depends on b2da_pkg
module b2da_checker (
  input logic                         clk_i,
  input logic                         rst_ni,
  input logic                         in_valid_i,
  input logic                         in_stall_o,
  input logic                         out_valid_o,
  input logic                         out_stall_i,
  input logic [b2da_pkg::CHAR_W-1:0]  character_o,
  input logic                         last_o
);
  import b2da_pkg::*;

  // every output request is a decimal digit
  a_digit_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (character_o >= CHAR_W'(48) && character_o <= CHAR_W'(57)))
    else $error("character outside the digit range");

  // a new request is held off while the previous one converts
  a_busy_after_request: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o) |=> in_stall_o)
    else $error("request taken while busy");

  // a request taken while no digit is pending registers no digit in its first conversion step
  a_no_early_digit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o && !out_valid_o) |=> ##1 !out_valid_o)
    else $error("digit produced before conversion could finish");

  // a stalled output request holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_stall_i) |=>
      (out_valid_o && $stable(character_o) && $stable(last_o)))
    else $error("stalled output request changed");

endmodule

bind binary_to_decimal_ascii b2da_checker u_b2da_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_stall_o  (in_stall_o),
  .out_valid_o (out_valid_o),
  .out_stall_i (out_stall_i),
  .character_o (character_o),
  .last_o      (last_o)
);

// ===== tb/sv/tb.sv =====
`timescale 1ns / 100ps
// tb: self-checking testbench for binary_to_decimal_ascii, with a digit scoreboard class
// depends on b2da_pkg and the binary_to_decimal_ascii rtl; reads no files

class digit_scoreboard;
  localparam int MAX_DIGITS = 10;
  localparam int DIGIT_BASE = 10;

  typedef struct packed {
    logic [b2da_pkg::CHAR_W-1:0] ch;
    logic                        last;
  } digit_t;

  digit_t      expected_digits[$];
  int unsigned errors;
  int unsigned numbers;
  int unsigned digits;

  task report(string what);
    errors++;
    $display("mismatch at %0t: %s", $time, what);
  endtask

  // predicts the decimal text of one accepted request
  function void note_value(logic [b2da_pkg::IN_BITS-1:0] value);
    logic [31:0] rest;
    logic [3:0]  rev [MAX_DIGITS];
    int          count;
    digit_t      d;
    rest = value;
    if (b2da_pkg::VALUE_BITS < 32) begin
      rest &= (32'd1 << b2da_pkg::VALUE_BITS) - 32'd1;
    end
    count = 0;
    do begin
      rev[count] = 4'(rest % DIGIT_BASE);
      rest = rest / DIGIT_BASE;
      count++;
    end while (rest != 0 && count < MAX_DIGITS);
    for (int k = count - 1; k >= 0; k--) begin
      d.ch   = b2da_pkg::ASCII_ZERO + b2da_pkg::CHAR_W'(rev[k]);
      d.last = (k == 0);
      expected_digits.push_back(d);
    end
    numbers++;
  endfunction

  task check_digit(logic [b2da_pkg::CHAR_W-1:0] ch, logic last);
    digit_t want;
    if (expected_digits.size() == 0) begin
      report($sformatf("digit %0d last %0b with no request pending", ch, last));
      return;
    end
    want = expected_digits.pop_front();
    digits++;
    if (ch !== want.ch) begin
      report($sformatf("character %0d, expected %0d", ch, want.ch));
    end
    if (last !== want.last) begin
      report($sformatf("last %0b, expected %0b", last, want.last));
    end
  endtask
endclass

module tb;
  localparam int CYCLE_LIMIT = 200000;
  localparam int HOLD_CYCLES = 400;

  logic                          clk;
  logic                          rst_n;
  logic                          in_valid;
  logic                          in_stall;
  logic [b2da_pkg::IN_BITS-1:0]  value;
  logic                          out_valid;
  logic                          out_stall;
  logic [b2da_pkg::CHAR_W-1:0]   character;
  logic                          last;

  digit_scoreboard sb = new();

  int unsigned cycle_count = 0;
  int          tx_gap_max  = 8;
  int          rx_gap_max  = 8;
  int          rx_hold     = 0;

  logic [31:0] corner_values [20] = '{
    32'd0, 32'd1, 32'd7, 32'd9, 32'd10, 32'd99, 32'd100, 32'd10000,
    32'd65535, 32'd90000000, 32'd999999999, 32'd1000000000, 32'd1000000001,
    32'd1234567890, 32'h5555_5555, 32'hAAAA_AAAA, 32'h8000_0000,
    32'd4000000000, 32'hFFFF_FFFE, 32'hFFFF_FFFF
  };

  binary_to_decimal_ascii dut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_stall_o  (in_stall),
    .value_i     (value),
    .out_valid_o (out_valid),
    .out_stall_i (out_stall),
    .character_o (character),
    .last_o      (last)
  );

  always #2 clk = ~clk;

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d digits still pending", cycle_count,
               sb.expected_digits.size());
      $display("CHECKS FAILED");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if (in_valid && !in_stall) begin
        sb.note_value(value);
      end
      if (out_valid && !out_stall) begin
        sb.check_digit(character, last);
      end
    end
  end

  function automatic logic [31:0] random_value();
    logic [31:0] lo;
    logic [31:0] hi;
    logic [31:0] p;
    int          n;
    case ($urandom_range(0, 9))
      0, 1, 2, 3: return $urandom();
      4, 5, 6: begin
        // uniform within a random digit count
        n  = $urandom_range(1, 10);
        lo = 1;
        repeat (n - 1) lo *= 10;
        if (n == 1) lo = 0;
        hi = (n == 10) ? 32'hFFFF_FFFF : ((n == 1) ? 32'd9 : lo * 10 - 1);
        return $urandom_range(hi, lo);
      end
      7: begin
        p = 1;
        repeat ($urandom_range(0, 9)) p *= 10;
        return p + $urandom_range(0, 2) - 1;
      end
      8: return $urandom_range(0, 99);
      default: return 32'hFFFF_FFFF - $urandom_range(0, 1000);
    endcase
  endfunction

  task send_value(input logic [31:0] v);
    int gap;
    gap = $urandom_range(0, tx_gap_max);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    value    <= v;
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  // output side: stall for a drawn number of cycles, or the set hold-off, then take one request
  initial begin
    int n;
    wait (rst_n === 1'b1);
    @(posedge clk);
    forever begin
      if (rx_hold > 0) begin
        n = rx_hold;
        rx_hold = 0;
      end else begin
        n = $urandom_range(0, rx_gap_max);
      end
      if (n > 0) begin
        out_stall <= 1'b1;
        repeat (n) @(posedge clk);
      end
      out_stall <= 1'b0;
      @(posedge clk);
      while (!out_valid) @(posedge clk);
    end
  end

  initial begin
    clk       = 1'b0;
    rst_n     = 1'b0;
    in_valid  = 1'b0;
    value     = '0;
    out_stall = 1'b0;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (corner_values[i]) send_value(corner_values[i]);

    // back to back on both sides
    tx_gap_max = 0;
    rx_gap_max = 0;
    repeat (100) send_value(random_value());

    // long output hold-off while requests keep coming
    rx_hold = HOLD_CYCLES;
    repeat (12) send_value(random_value());

    tx_gap_max = 8;
    rx_gap_max = 8;
    repeat (80) send_value(random_value());
    tx_gap_max = 0;
    repeat (60) send_value(random_value());
    in_valid <= 1'b0;

    while (sb.expected_digits.size() != 0) @(posedge clk);
    repeat (60) @(posedge clk);

    $display("converted %0d numbers into %0d digits: corner values, random lengths,",
             sb.numbers, sb.digits);
    $display("random gaps on both sides and a %0d-cycle output hold-off", HOLD_CYCLES);
    if (sb.errors == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("%0d mismatches", sb.errors);
      $display("CHECKS FAILED");
    end
    $finish;
  end
endmodule
